[rtl/core/cctk_pkg.sv]
// ----------------------------------------------------------------------------
// cctk_pkg: shared types and codes for the compaction candidate top-K unit
// Holds the list entry layout, the action codes and the sequencer states.
// ----------------------------------------------------------------------------
package cctk_pkg;

  localparam int unsigned SECTOR_W  = 16;
  localparam int unsigned TRAPPED_W = 16;
  localparam int unsigned ROOTS_W   = 16;
  localparam int unsigned LIVE_W    = 32;
  localparam int unsigned FREE_W    = 21;
  localparam int unsigned SIZE_W    = 21;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned RANK_W    = 4;
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned ACC_W     = LIVE_W + 1;

  localparam logic [TRAPPED_W-1:0] TRAPPED_MAX = '1;
  localparam logic [SIZE_W-1:0]    SECTOR_BYTES_RESET = 21'd4096;

  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_OFFER = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

  typedef struct packed {
    logic [SECTOR_W-1:0]  sector;
    logic [TRAPPED_W-1:0] trapped;
    logic [ROOTS_W-1:0]   roots;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_TRAP,
    ST_LAST,
    ST_SHIFT,
    ST_EMIT
  } state_t;

endpackage

[rtl/core/cctk_rank_cmp.sv]
// ----------------------------------------------------------------------------
// cctk_rank_cmp: ranking comparator
// Tells whether one entry strictly ranks above another: non-empty first, then
// more trapped bytes, then more live roots. Equal entries do not rank above.
// ----------------------------------------------------------------------------
module cctk_rank_cmp (
  input  cctk_pkg::entry_t a,
  input  cctk_pkg::entry_t b,
  output logic             above
);
  import cctk_pkg::*;

  always_comb begin
    priority if (a.sector == '0) begin
      above = 1'b0;
    end else if (b.sector == '0) begin
      above = 1'b1;
    end else if (a.trapped != b.trapped) begin
      above = (a.trapped > b.trapped);
    end else begin
      above = (a.roots > b.roots);
    end
  end

endmodule

[rtl/core/compaction_candidate_top_k_unit.sv]
// ----------------------------------------------------------------------------
// compaction_candidate_top_k_unit: sorted list of the best sectors to compact
// Keeps LIST_DEPTH candidates ordered by trapped bytes, then root count.
// ----------------------------------------------------------------------------
// One item is handled at a time. A clear, a read or an unused action code
// goes straight to the emit step once accepted. An offer first computes its
// trapped space (the byte sum, then the subtract and saturate); the single
// shared ranking comparator then checks it against the last list position
// and, if it ranks above, visits list positions while the offer moves toward
// the front; a rejected offer goes straight to the emit step. A result waits
// in the output register while the next item is accepted; a result that
// finds the register still full waits until it drains.
module compaction_candidate_top_k_unit #(
  parameter int unsigned LIST_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: sector_bytes.
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sector_number[15:0], live_total[47:16], free_bytes[68:48],
  // root_count[84:69], read_slot[88:85], zero fill[95:89]
  input  logic [95:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // accepted[0], placed_rank[4:1], entry_sector[20:5], entry_trapped[36:21],
  // entry_roots[52:37], zero fill[55:53]
  output logic [55:0] m_axis_tdata
);
  import cctk_pkg::*;

  localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIST_DEPTH - 1);

  state_t state, state_next;

  logic [SIZE_W-1:0]   sector_bytes;
  entry_t              list [LIST_DEPTH];

  // Captured offer.
  logic [SECTOR_W-1:0] in_sector;
  logic [LIVE_W-1:0]   in_live;
  logic [FREE_W-1:0]   in_free;
  logic [ROOTS_W-1:0]  in_roots;
  logic [ACC_W-1:0]    acc;
  entry_t              cand;
  logic [IDX_W-1:0]    pos;

  // Pending result.
  logic                res_accepted;
  logic [RANK_W-1:0]   res_rank;
  entry_t              res_entry;

  // Decoded input item.
  logic [ACTION_W-1:0] act;
  logic [SLOT_W-1:0]   slot;
  logic                slot_ok;
  logic                in_fire;

  // Shared comparator and its read port.
  logic [IDX_W-1:0]    rd_idx;
  entry_t              rd_entry;
  logic                cand_above;

  // Sequencer controls.
  logic                list_clr;
  logic                list_we;
  logic [IDX_W-1:0]    list_wa;
  entry_t              list_wd;
  logic                pos_load;
  logic                pos_dec;
  logic                res_load;
  logic                res_acc_next;
  logic [RANK_W-1:0]   res_rank_next;
  entry_t              res_entry_next;
  logic                out_load;

  // Trapped space.
  logic [ACC_W:0]      diff;
  logic [TRAPPED_W-1:0] trapped;

  assign act     = s_axis_tuser;
  assign slot    = s_axis_tdata[88:85];
  assign slot_ok = ({1'b0, slot} < 5'(LIST_DEPTH));
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  assign diff = {{(ACC_W + 1 - SIZE_W){1'b0}}, sector_bytes} - {1'b0, acc};

  always_comb begin
    if (diff[ACC_W]) begin
      trapped = '0;
    end else if (|diff[ACC_W-1:TRAPPED_W]) begin
      trapped = TRAPPED_MAX;
    end else begin
      trapped = diff[TRAPPED_W-1:0];
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE:  rd_idx = slot_ok ? slot[IDX_W-1:0] : '0;
      ST_LAST:  rd_idx = LAST_IDX;
      ST_SHIFT: rd_idx = (pos != '0) ? pos - IDX_W'(1) : '0;
      default:  rd_idx = '0;
    endcase
  end

  assign rd_entry = list[rd_idx];

  cctk_rank_cmp u_cmp (
    .a     (cand),
    .b     (rd_entry),
    .above (cand_above)
  );

  // Sequencer: next state and controls.
  always_comb begin
    state_next     = state;
    list_clr       = 1'b0;
    list_we        = 1'b0;
    list_wa        = pos;
    list_wd        = cand;
    pos_load       = 1'b0;
    pos_dec        = 1'b0;
    res_load       = 1'b0;
    res_acc_next   = 1'b0;
    res_rank_next  = '0;
    res_entry_next = '0;
    out_load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          res_load = 1'b1;
          if (act == ACT_OFFER) begin
            state_next = ST_SUM;
          end else begin
            state_next = ST_EMIT;
            if (act == ACT_CLEAR) list_clr = 1'b1;
            if (act == ACT_READ && slot_ok) res_entry_next = rd_entry;
          end
        end
      end
      ST_SUM: begin
        state_next = ST_TRAP;
      end
      ST_TRAP: begin
        state_next = ST_LAST;
      end
      ST_LAST: begin
        if (cand_above) begin
          pos_load   = 1'b1;
          state_next = ST_SHIFT;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_SHIFT: begin
        list_we = 1'b1;
        if (pos != '0 && cand_above) begin
          // Move the entry ahead down one place; the offer keeps climbing.
          list_wd = rd_entry;
          pos_dec = 1'b1;
        end else begin
          res_load      = 1'b1;
          res_acc_next  = 1'b1;
          res_rank_next = RANK_W'(pos);
          state_next    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_bytes <= SECTOR_BYTES_RESET;
    end else if (cfg_we) begin
      sector_bytes <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || list_clr) begin
      for (int i = 0; i < LIST_DEPTH; i++) list[i] <= '0;
    end else if (list_we) begin
      list[list_wa] <= list_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_sector <= s_axis_tdata[15:0];
      in_live   <= s_axis_tdata[47:16];
      in_free   <= s_axis_tdata[68:48];
      in_roots  <= s_axis_tdata[84:69];
    end
    if (state == ST_SUM) begin
      acc <= {1'b0, in_live} + {{(ACC_W - FREE_W){1'b0}}, in_free};
    end
    if (state == ST_TRAP) begin
      cand.sector  <= in_sector;
      cand.trapped <= trapped;
      cand.roots   <= in_roots;
    end
    if (pos_load) begin
      pos <= LAST_IDX;
    end else if (pos_dec) begin
      pos <= pos - IDX_W'(1);
    end
    if (res_load) begin
      res_accepted <= res_acc_next;
      res_rank     <= res_rank_next;
      res_entry    <= res_entry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {3'b000, res_entry.roots, res_entry.trapped, res_entry.sector,
                       res_rank, res_accepted};
    end
  end

  // The insertion pointer never leaves the list.
  a_pos_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> (32'(pos) < LIST_DEPTH))
    else $error("insertion pointer beyond the list");

  // A delivered rank always names a list position.
  a_rank_in_list: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (32'(m_axis_tdata[4:1]) < LIST_DEPTH))
    else $error("placed rank beyond the list");

  // A result never carries both an accepted offer and a read entry.
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[52:5] == '0))
    else $error("offer result carries entry fields");

endmodule
